// ----- rtl/single_hash_bit_filter_macros.svh -----
// assertion macros for the single hash bit filter
// used by the modules that carry concurrent checks; needs clk and rst_n in scope
`ifndef SINGLE_HASH_BIT_FILTER_MACROS_SVH
`define SINGLE_HASH_BIT_FILTER_MACROS_SVH

`ifndef SYNTH
// plain property checked every cycle out of reset
`define SHBF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("shbf assertion failed");
// same-cycle implication
`define SHBF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shbf implication failed");
// next-cycle implication
`define SHBF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shbf next-cycle implication failed");
`else
`define SHBF_ASSERT(lbl, prop)
`define SHBF_ASSERT_IMP(lbl, ante, cons)
`define SHBF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/shbf_pkg.sv -----
// shared types and constants of the single hash bit filter
// no dependencies
package shbf_pkg;

    localparam int FILTER_BYTES = 131072;
    localparam int ADDR_W       = $clog2(FILTER_BYTES);
    localparam int SIZE_EFF_W   = ADDR_W + 1;
    localparam int MULT_W       = 8;
    localparam int CHAR_W       = 8;
    localparam int BIT_W        = 3;
    localparam int SIZE_W       = 18;
    localparam int PROD_W       = MULT_W + ADDR_W;
    localparam int CNT_W        = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 18;

    localparam logic [MULT_W-1:0] BYTE_MULT_RST = 8'd33;
    localparam logic [MULT_W-1:0] BIT_MULT_RST  = 8'd34;
    localparam logic [SIZE_W-1:0] SIZE_RST      = 18'd74383;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MULT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MULT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 2'd2;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } item_t;

    typedef struct packed {
        logic              present;
        logic [ADDR_W-1:0] byte_index;
        logic [BIT_W-1:0]  bit_index;
    } result_t;

    typedef struct packed {
        logic [MULT_W-1:0]     byte_mult;
        logic [MULT_W-1:0]     bit_mult;
        logic [SIZE_EFF_W-1:0] size;
    } cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_DIV,
        S_READ,
        S_RMW
    } state_t;

endpackage

// ----- rtl/shbf_cfg.sv -----
// configuration registers and effective filter size
// depends on shbf_pkg
module shbf_cfg
    import shbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [MULT_W-1:0] byte_mult_reg;
    logic [MULT_W-1:0] bit_mult_reg;
    logic [SIZE_W-1:0] size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_mult_reg <= BYTE_MULT_RST;
            bit_mult_reg  <= BIT_MULT_RST;
            size_reg      <= SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BYTE_MULT: byte_mult_reg <= cfg_data[MULT_W-1:0];
                CFG_BIT_MULT:  bit_mult_reg  <= cfg_data[MULT_W-1:0];
                CFG_SIZE:      size_reg      <= cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    // zero acts as one, oversize saturates to the memory depth
    always_comb
    begin
        cfg.byte_mult = byte_mult_reg;
        cfg.bit_mult  = bit_mult_reg;
        if (size_reg == '0)
            cfg.size = SIZE_EFF_W'(1);
        else if (32'(size_reg) > 32'(FILTER_BYTES))
            cfg.size = SIZE_EFF_W'(FILTER_BYTES);
        else
            cfg.size = SIZE_EFF_W'(size_reg);
    end

endmodule

// ----- rtl/shbf_rem.sv -----
// shift-subtract remainder unit, one dividend bit per cycle
// depends on shbf_pkg and single_hash_bit_filter_macros.svh
`include "single_hash_bit_filter_macros.svh"
module shbf_rem
    import shbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PROD_W-1:0]     dividend,
    input  logic [SIZE_EFF_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [ADDR_W-1:0]     remainder
);

    logic [PROD_W-1:0]     dvd_reg;
    logic [SIZE_EFF_W-1:0] div_reg;
    logic [ADDR_W-1:0]     rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [ADDR_W:0]       trial;
    logic                  ge;
    logic [ADDR_W-1:0]     rem_next;

    // running remainder stays below the divisor, so it fits in ADDR_W bits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[PROD_W-1]};
        ge       = SIZE_EFF_W'(trial) >= div_reg;
        rem_next = ge ? ADDR_W'(SIZE_EFF_W'(trial) - div_reg) : trial[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

    `SHBF_ASSERT_IMP(a_rem_start_idle, start, !busy_reg)
    `SHBF_ASSERT_IMP(a_rem_below_div, done_reg, SIZE_EFF_W'(rem_reg) < div_reg)
    `SHBF_ASSERT_NXT(a_rem_done_pulse, done_reg, !done_reg && !busy_reg)

endmodule

// ----- rtl/shbf_mem.sv -----
// filter byte memory, one write port and one registered read port
// depends on shbf_pkg
module shbf_mem
    import shbf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [FILTER_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/single_hash_bit_filter.sv -----
// top level of the single hash bit filter: sequencer, hash state, result register
// depends on shbf_pkg, shbf_cfg, shbf_rem, shbf_mem and the macro header
//
//   channel  | signals                                   | transfer
//   ---------+-------------------------------------------+------------------------------
//   item     | start, busy, item (item_t)                | start high while busy low
//   result   | result_valid, result (result_t)           | one cycle strobe, no stall
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | valid and ready both high
//
// each character goes from its transfer through a state that forms multiplier times hash
// plus character, 25 steps of the shift-subtract remainder unit (one per bit of the
// product) and a state that takes the remainder back, to idle for the next transfer;
// insert and query add a read state and a read-modify-write state on the last character
// of a word, and only an insert writes the filter memory there.
// after reset the memory is swept to zero, one byte per cycle over all 131072 bytes,
// with busy high; config writes are taken throughout. results cannot be held off.
`include "single_hash_bit_filter_macros.svh"
module single_hash_bit_filter
    import shbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t            state_reg, state_next;
    cfg_t              cfg;
    item_t             item_reg;
    logic [ADDR_W-1:0] byte_hash_reg;
    logic [BIT_W-1:0]  bit_hash_reg;
    logic [ADDR_W-1:0] fin_byte_reg;
    logic [BIT_W-1:0]  fin_bit_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              result_valid_reg;
    result_t           result_reg;
    logic              accept;
    logic              rem_start, rem_busy, rem_done;
    logic [ADDR_W-1:0] rem_value;
    logic [PROD_W-1:0] product;
    logic [5:0]        bit_prod;
    logic [BIT_W-1:0]  bit_hash_next;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              is_insert, is_query;

    shbf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    shbf_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (product),
        .divisor   (cfg.size),
        .busy      (rem_busy),
        .done      (rem_done),
        .remainder (rem_value)
    );

    shbf_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (fin_byte_reg),
        .rdata (mem_rdata)
    );

    assign accept    = start && !busy;
    assign is_insert = item_reg.req_type == REQ_INSERT;
    assign is_query  = item_reg.req_type == REQ_QUERY;

    // product is registered inside the remainder unit
    always_comb
    begin
        product = PROD_W'(cfg.byte_mult) * PROD_W'(byte_hash_reg)
                  + PROD_W'(item_reg.char_code);
        bit_prod      = 6'(cfg.bit_mult[BIT_W-1:0]) * 6'(bit_hash_reg);
        bit_hash_next = bit_prod[BIT_W-1:0] + item_reg.char_code[BIT_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_addr_reg == ADDR_W'(FILTER_BYTES - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (start)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_DIV;
            S_DIV:
                if (rem_done)
                begin
                    if (item_reg.last_char && (is_insert || is_query))
                        state_next = S_READ;
                    else
                        state_next = S_IDLE;
                end
            S_READ:
                state_next = S_RMW;
            S_RMW:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy      = 1'b1;
        rem_start = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = fin_byte_reg;
        mem_wdata = mem_rdata | 8'(8'd1 << fin_bit_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            S_IDLE:  busy      = 1'b0;
            S_MUL:   rem_start = 1'b1;
            S_DIV:   ;
            S_READ:  mem_re    = 1'b1;
            S_RMW:   mem_we    = is_insert;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            byte_hash_reg    <= '0;
            bit_hash_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= 1'b0;
            if (state_reg == S_CLEAR)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (state_reg == S_MUL)
                bit_hash_reg <= bit_hash_next;
            if (state_reg == S_DIV && rem_done)
            begin
                if (item_reg.last_char)
                begin
                    byte_hash_reg <= '0;
                    bit_hash_reg  <= '0;
                    if (!is_insert && !is_query)
                        result_valid_reg <= 1'b1;
                end
                else
                    byte_hash_reg <= rem_value;
            end
            if (state_reg == S_RMW && is_query)
                result_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (state_reg == S_DIV && rem_done && item_reg.last_char)
        begin
            fin_byte_reg <= rem_value;
            fin_bit_reg  <= bit_hash_reg;
            result_reg   <= '{present: 1'b0, byte_index: rem_value,
                              bit_index: bit_hash_reg};
        end
        if (state_reg == S_RMW)
            result_reg <= '{present: mem_rdata[fin_bit_reg], byte_index: fin_byte_reg,
                            bit_index: fin_bit_reg};
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SHBF_ASSERT_NXT(a_result_single, result_valid_reg, !result_valid_reg)
    `SHBF_ASSERT_IMP(a_no_insert_result, result_valid_reg, item_reg.req_type != REQ_INSERT)
    `SHBF_ASSERT_IMP(a_rem_only_in_div, rem_busy || rem_done, state_reg == S_DIV)

endmodule

// ----- verif/shbf_checker.sv -----
// checker for the single hash bit filter: mirrors the registers, hash state and filter memory,
// predicts the result of every word that is not an insert and compares it with what the block reports
// depends on shbf_pkg
module shbf_checker
    import shbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  item_t                 item,
    input  logic                  result_valid,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    words_open,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MULT_W-1:0] byte_mult_q;
    logic [MULT_W-1:0] bit_mult_q;
    logic [SIZE_W-1:0] size_q;
    logic [ADDR_W-1:0] byte_acc;
    logic [BIT_W-1:0]  bit_acc;
    logic [7:0]        filter_copy [FILTER_BYTES];
    result_t           word_results_q [$];
    int                err_cnt;
    int                seen_cnt;

    // advance both hashes by one character; on the last one act on the word
    task automatic hash_char(item_t it);
        int unsigned m;
        int unsigned prod;
        result_t     r;
        m = (size_q == '0) ? 1 : ((size_q > FILTER_BYTES) ? FILTER_BYTES : 32'(size_q));
        prod = 32'(byte_mult_q) * 32'(byte_acc) + 32'(it.char_code);
        byte_acc = ADDR_W'(prod % m);
        bit_acc = BIT_W'(32'(bit_mult_q) * 32'(bit_acc) + 32'(it.char_code));
        if (it.last_char)
        begin
            if (it.req_type == REQ_INSERT)
            begin
                filter_copy[byte_acc][bit_acc] = 1'b1;
            end
            else
            begin
                r.present    = (it.req_type == REQ_QUERY) ? filter_copy[byte_acc][bit_acc] : 1'b0;
                r.byte_index = byte_acc;
                r.bit_index  = bit_acc;
                word_results_q.push_back(r);
            end
            byte_acc = '0;
            bit_acc  = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            byte_mult_q = BYTE_MULT_RST;
            bit_mult_q  = BIT_MULT_RST;
            size_q      = SIZE_RST;
            byte_acc    = '0;
            bit_acc     = '0;
            foreach (filter_copy[i])
                filter_copy[i] = '0;
            word_results_q.delete();
            err_cnt  = 0;
            seen_cnt = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BYTE_MULT: byte_mult_q = cfg_data[MULT_W-1:0];
                    CFG_BIT_MULT:  bit_mult_q  = cfg_data[MULT_W-1:0];
                    CFG_SIZE:      size_q      = cfg_data[SIZE_W-1:0];
                    default:       ;
                endcase
            end
            // a result can never belong to the item taken on the same edge
            if (result_valid)
            begin
                seen_cnt++;
                if (word_results_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: present %0d byte %0d bit %0d",
                                 result.present, result.byte_index, result.bit_index);
                end
                else
                begin
                    exp_r = word_results_q.pop_front();
                    if (result.present !== exp_r.present ||
                        result.byte_index !== exp_r.byte_index ||
                        result.bit_index !== exp_r.bit_index)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("result mismatch: expected present %0d byte %0d bit %0d, got present %0d byte %0d bit %0d",
                                     exp_r.present, exp_r.byte_index, exp_r.bit_index,
                                     result.present, result.byte_index, result.bit_index);
                    end
                end
            end
            if (start && !busy)
                hash_char(item);
        end
        mismatches   <= err_cnt;
        words_open   <= word_results_q.size();
        results_seen <= seen_cnt;
    end

endmodule

// ----- verif/tb_single_hash_bit_filter.sv -----
// testbench top for the single hash bit filter: clock, reset, character and register stimulus
// depends on shbf_pkg, single_hash_bit_filter and shbf_checker
module tb_single_hash_bit_filter;
    import shbf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [1:0] REQ_HASH  = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int words_open;
    int results_seen;
    int idle_pct;
    int chars_sent;
    int words_sent;
    int settings_used;

    single_hash_bit_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    shbf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .words_open   (words_open),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // covers the memory clearing sweep after reset many times over
    initial
    begin
        #20_000_000;
        $display("tb_single_hash_bit_filter failed");
        $finish;
    end

    // one character transfer, with random idle cycles ahead of it
    task automatic send_char(logic [1:0] req, logic [7:0] ch, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{req_type: req, char_code: ch, last_char: last};
        do
            @(posedge clk);
        while (busy);
        chars_sent++;
        if (last)
            words_sent++;
    endtask

    // narrow words come from a four letter alphabet so that queries hit often
    task automatic send_word(logic [1:0] req, bit narrow);
        int         len;
        logic [7:0] ch;
        len = narrow ? $urandom_range(1, 3) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            ch = narrow ? 8'($urandom_range(97, 100)) : 8'($urandom_range(1, 255));
            if ($urandom_range(99) == 0)
                ch = 8'd0;
            send_char((i == len - 1) ? req : 2'($urandom_range(3)), ch, i == len - 1);
        end
    endtask

    // hold off until every result is in and the block has settled
    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (words_open != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_phase(logic [7:0] byte_mult, logic [7:0] bit_mult,
                             logic [CFG_DATA_W-1:0] size);
        drain();
        write_reg(CFG_BYTE_MULT, CFG_DATA_W'(byte_mult));
        write_reg(CFG_BIT_MULT, CFG_DATA_W'(bit_mult));
        write_reg(CFG_SIZE, size);
        settings_used++;
    endtask

    initial
    begin
        int         r;
        logic [1:0] req;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        idle_pct      = 0;
        chars_sent    = 0;
        words_sent    = 0;
        settings_used = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // index past the register list must leave the defaults alone
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

        // directed words on the reset settings
        send_char(REQ_INSERT, 8'd1, 1'b1);
        send_char(REQ_QUERY, 8'd1, 1'b1);
        send_char(REQ_QUERY, 8'd255, 1'b1);
        send_char(REQ_QUERY, 8'h61, 1'b0);
        send_char(REQ_INSERT, 8'h62, 1'b1);
        send_char(REQ_HASH, 8'h61, 1'b0);
        send_char(REQ_QUERY, 8'h62, 1'b1);
        send_char(REQ_INSERT, 8'd0, 1'b0);
        send_char(REQ_HASH, 8'h80, 1'b1);
        send_char(REQ_SPARE, 8'h55, 1'b1);
        for (int i = 0; i < 6; i++)
            send_char(REQ_HASH, 8'hff, i == 5);

        // zero size behaves as one
        set_phase(8'd0, 8'd0, '0);
        send_char(REQ_QUERY, 8'h7f, 1'b0);
        send_char(REQ_QUERY, 8'h01, 1'b1);
        send_char(REQ_INSERT, 8'hfe, 1'b1);

        // oversize saturates to the full memory
        set_phase(8'hff, 8'hff, 18'h3ffff);
        for (int i = 0; i < 4; i++)
            send_char(REQ_HASH, 8'hff, i == 3);

        // register change in the middle of a word
        send_char(REQ_HASH, 8'hff, 1'b0);
        send_char(REQ_HASH, 8'hfe, 1'b0);
        set_phase(8'hff, 8'hff, 18'd8);
        send_char(REQ_QUERY, 8'hff, 1'b1);

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: begin set_phase(BYTE_MULT_RST, BIT_MULT_RST, SIZE_RST); idle_pct = 0; end
                1: begin set_phase(8'd0, 8'd0, 18'd1); idle_pct = 76; end
                2: begin set_phase(8'hff, 8'hff, 18'd131072); idle_pct = 8; end
                3: begin set_phase(8'hff, 8'hff, 18'h3ffff); idle_pct = 0; end
                4:
                begin
                    set_phase(8'($urandom), 8'($urandom), 18'd8);
                    idle_pct = 76;
                end
                5:
                begin
                    set_phase(8'($urandom), 8'($urandom), 18'($urandom_range(1, 131072)));
                    idle_pct = 0;
                end
                6: begin set_phase(8'd1, 8'd1, '0); idle_pct = 8; end
                7:
                begin
                    set_phase(8'($urandom), 8'($urandom), 18'($urandom_range(0, 262143)));
                    idle_pct = 76;
                end
                8:
                begin
                    set_phase(8'($urandom), 8'($urandom), 18'($urandom_range(1, 64)));
                    idle_pct = 0;
                end
                default: begin set_phase(BYTE_MULT_RST, BIT_MULT_RST, SIZE_RST); idle_pct = 8; end
            endcase
            for (int w = 0; w < 34; w++)
            begin
                r = $urandom_range(99);
                if (r < 40)
                    req = REQ_INSERT;
                else if (r < 80)
                    req = REQ_QUERY;
                else if (r < 95)
                    req = REQ_HASH;
                else
                    req = REQ_SPARE;
                send_word(req, $urandom_range(1));
            end
            // sometimes leave a word open across the register change
            if ($urandom_range(1))
                send_char(2'($urandom_range(3)), 8'($urandom), 1'b0);
        end

        drain();
        $display("covered %0d characters in %0d words over %0d register settings, %0d results checked",
                 chars_sent, words_sent, settings_used, results_seen);
        $display("%0d mismatches, %0d expected results outstanding", mismatches, words_open);
        if (mismatches == 0 && words_open == 0)
            $display("tb_single_hash_bit_filter passed");
        else
            $display("tb_single_hash_bit_filter failed");
        $finish;
    end

endmodule
